/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands for the record sorter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while reset is held
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while reset is held
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mkrs_pkg.sv */
// ----------------------------------------------------------------------------
// mkrs_pkg
// Shared types and constants of the multi-key record sorter.
// ----------------------------------------------------------------------------
package mkrs_pkg;

    localparam int GROUP_W    = 32;
    localparam int GROUP_NUM  = 4;
    localparam int TIME_W     = 64;
    localparam int ANT_W      = 16;
    localparam int ROW_W      = 48;
    localparam int USED_W     = 3;
    localparam int DATA_W     = GROUP_NUM * GROUP_W + TIME_W + 2 * ANT_W + ROW_W;
    localparam int TAIL_KEY_W = TIME_W + 2 * ANT_W;

    typedef struct packed {
        logic [TIME_W-1:0] time_bits;
        logic [ANT_W-1:0]  antenna_first;
        logic [ANT_W-1:0]  antenna_second;
        logic [ROW_W-1:0]  row_id;
    } tail_t;

    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_UP,
        SEL_DN
    } sel_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic sort;
        logic phase;
        logic shift;
    } cmd_t;

endpackage

/* sv/mkrs_cell.sv */
// ----------------------------------------------------------------------------
// mkrs_cell
// One slot of the sort chain: holds a record, forms its ordering key and
// compares it against the neighbor above.
// ----------------------------------------------------------------------------
module mkrs_cell #(
    parameter int KEYS = 4
) (
    input  logic                                      aclk,
    input  mkrs_pkg::sel_t                            sel,
    input  logic [mkrs_pkg::USED_W-1:0]               used,
    input  logic [KEYS-1:0][mkrs_pkg::GROUP_W-1:0]    in_groups,
    input  mkrs_pkg::tail_t                           in_tail,
    input  logic [KEYS-1:0][mkrs_pkg::GROUP_W-1:0]    up_groups,
    input  mkrs_pkg::tail_t                           up_tail,
    input  logic [KEYS-1:0][mkrs_pkg::GROUP_W-1:0]    dn_groups,
    input  mkrs_pkg::tail_t                           dn_tail,
    input  logic [KEYS*mkrs_pkg::GROUP_W+mkrs_pkg::TAIL_KEY_W-1:0] up_key,
    output logic [KEYS-1:0][mkrs_pkg::GROUP_W-1:0]    groups_q,
    output mkrs_pkg::tail_t                           tail_q,
    output logic [KEYS*mkrs_pkg::GROUP_W+mkrs_pkg::TAIL_KEY_W-1:0] key,
    output logic                                      after_up
);

    localparam int GK_W = KEYS * mkrs_pkg::GROUP_W;

    logic [KEYS-1:0][mkrs_pkg::GROUP_W-1:0] groups_reg;
    mkrs_pkg::tail_t                        tail_reg;
    logic [GK_W-1:0]                        gkey;
    logic [mkrs_pkg::TIME_W-1:0]            tkey;

    function automatic logic [mkrs_pkg::TIME_W-1:0] time_key(
        input logic [mkrs_pkg::TIME_W-1:0] t
    );
        logic [mkrs_pkg::TIME_W-1:0] z;
        z = (t == {1'b1, {(mkrs_pkg::TIME_W-1){1'b0}}}) ? '0 : t;
        if (z[mkrs_pkg::TIME_W-1]) begin
            return ~z;
        end
        return {1'b1, z[mkrs_pkg::TIME_W-2:0]};
    endfunction

    always_ff @(posedge aclk) begin
        case (sel)
            mkrs_pkg::SEL_LOAD: begin
                groups_reg <= in_groups;
                tail_reg   <= in_tail;
            end
            mkrs_pkg::SEL_UP: begin
                groups_reg <= up_groups;
                tail_reg   <= up_tail;
            end
            mkrs_pkg::SEL_DN: begin
                groups_reg <= dn_groups;
                tail_reg   <= dn_tail;
            end
            default: begin
                groups_reg <= groups_reg;
                tail_reg   <= tail_reg;
            end
        endcase
    end

    always_comb begin
        gkey = '0;
        for (int g = 0; g < KEYS; g++) begin
            if (mkrs_pkg::USED_W'(g) < used) begin
                gkey[(KEYS-g)*mkrs_pkg::GROUP_W-1 -: mkrs_pkg::GROUP_W] =
                    groups_reg[g] ^ {1'b1, {(mkrs_pkg::GROUP_W-1){1'b0}}};
            end
        end
        tkey = time_key(tail_reg.time_bits);
    end

    assign key      = {gkey, tkey, tail_reg.antenna_first, tail_reg.antenna_second};
    assign after_up = key > up_key;
    assign groups_q = groups_reg;
    assign tail_q   = tail_reg;

endmodule

/* sv/mkrs_ctrl.sv */
// ----------------------------------------------------------------------------
// mkrs_ctrl
// Sequencer of the sorter: load, odd-even sort passes, drain.
// ----------------------------------------------------------------------------
module mkrs_ctrl #(
    parameter int MAX_ROWS = 64,
    parameter int KEYS     = 4,
    parameter int CW       = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mkrs_pkg::USED_W-1:0] cfg_wr_data,
    input  logic                        s_tvalid,
    input  logic                        s_tlast,
    input  logic                        out_free,
    output logic                        s_tready,
    output mkrs_pkg::cmd_t              cmd,
    output logic [CW-1:0]               count,
    output logic [mkrs_pkg::USED_W-1:0] used,
    output logic                        ovf,
    output logic                        last_emit
);

    mkrs_pkg::state_t              state_reg, state_next;
    logic [mkrs_pkg::USED_W-1:0]   groups_in_use_reg, groups_in_use_next;
    logic [mkrs_pkg::USED_W-1:0]   used_reg, used_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 pass_reg, pass_next;
    logic                          phase_reg, phase_next;
    logic                          ovf_reg, ovf_next;
    logic                          room;
    logic                          req;

    assign room = count_reg < CW'(MAX_ROWS);
    assign req  = s_tvalid && (state_reg == mkrs_pkg::ST_LOAD);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mkrs_pkg::ST_LOAD: begin
                if (req && s_tlast) begin
                    state_next = mkrs_pkg::ST_SORT;
                end
            end
            mkrs_pkg::ST_SORT: begin
                if ((pass_reg + CW'(1)) == count_reg) begin
                    state_next = mkrs_pkg::ST_EMIT;
                end
            end
            mkrs_pkg::ST_EMIT: begin
                if (out_free && count_reg == CW'(1)) begin
                    state_next = mkrs_pkg::ST_LOAD;
                end
            end
            default: state_next = mkrs_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        s_tready  = state_reg == mkrs_pkg::ST_LOAD;
        cmd.load  = req && room;
        cmd.sort  = state_reg == mkrs_pkg::ST_SORT;
        cmd.phase = phase_reg;
        cmd.shift = (state_reg == mkrs_pkg::ST_EMIT) && out_free;
        last_emit = count_reg == CW'(1);
    end

    always_comb begin
        groups_in_use_next = cfg_wr_en ? cfg_wr_data : groups_in_use_reg;
        used_next          = used_reg;
        count_next         = count_reg;
        pass_next          = pass_reg;
        phase_next         = phase_reg;
        ovf_next           = ovf_reg;
        if (req) begin
            if (room) begin
                count_next = count_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
            if (s_tlast) begin
                used_next  = (groups_in_use_reg > mkrs_pkg::USED_W'(KEYS)) ?
                             mkrs_pkg::USED_W'(KEYS) : groups_in_use_reg;
                pass_next  = '0;
                phase_next = 1'b0;
            end
        end
        if (cmd.sort) begin
            pass_next  = pass_reg + CW'(1);
            phase_next = ~phase_reg;
        end
        if (cmd.shift) begin
            count_next = count_reg - CW'(1);
            if (last_emit) begin
                ovf_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= mkrs_pkg::ST_LOAD;
            groups_in_use_reg <= '0;
            used_reg          <= '0;
            count_reg         <= '0;
            pass_reg          <= '0;
            phase_reg         <= 1'b0;
            ovf_reg           <= 1'b0;
        end else begin
            state_reg         <= state_next;
            groups_in_use_reg <= groups_in_use_next;
            used_reg          <= used_next;
            count_reg         <= count_next;
            pass_reg          <= pass_next;
            phase_reg         <= phase_next;
            ovf_reg           <= ovf_next;
        end
    end

    assign count = count_reg;
    assign used  = used_reg;
    assign ovf   = ovf_reg;

endmodule

/* sv/multi_key_record_sorter.sv */
// ----------------------------------------------------------------------------
// multi_key_record_sorter
// Collects records into a chain of cells, sorts them by odd-even
// transposition on the group keys in use, time, then both antennas, and
// drains them in ascending order.
// ----------------------------------------------------------------------------
// channel  dir  tdata                             tuser          tlast
// s_       in   keys 0..3, time, ant1, ant2, row  -              last_in
// m_       out  keys 0..3, time, ant1, ant2, row  overflow_flag  last_out
// cfg_     in   groups_in_use (3 bits)            -              -
//
// Loading takes one record per cycle. After the last request the chain runs
// n sort passes (n = records held, one pass per cycle), then drains one record
// per cycle while m_tready is high. s_tready is low from the last request
// until the final record enters the output register. Reset clears control
// state only.
// ----------------------------------------------------------------------------
module multi_key_record_sorter #(
    parameter int MAX_ROWS       = 64,
    parameter int MAX_GROUP_KEYS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mkrs_pkg::USED_W-1:0] cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // group_key_0..3, time_bits, antenna_first, antenna_second, row_id
    input  logic [mkrs_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // out_group_0..3, out_time_bits, out_antenna_first, out_antenna_second,
    // out_row_id
    output logic [mkrs_pkg::DATA_W-1:0] m_tdata,
    // overflow_flag
    output logic                        m_tuser,
    output logic                        m_tlast
);

    localparam int KEYS   = MAX_GROUP_KEYS;
    localparam int CW     = $clog2(MAX_ROWS + 1);
    localparam int IW     = $clog2(MAX_ROWS);
    localparam int GW     = mkrs_pkg::GROUP_W;
    localparam int GK_W   = KEYS * GW;
    localparam int KEY_W  = GK_W + mkrs_pkg::TAIL_KEY_W;
    localparam int TAIL0  = mkrs_pkg::GROUP_NUM * GW;

    mkrs_pkg::cmd_t              cmd;
    logic [CW-1:0]               count;
    logic [mkrs_pkg::USED_W-1:0] used;
    logic                        ovf;
    logic                        last_emit;
    logic                        out_free;

    logic [KEYS-1:0][GW-1:0]     in_groups;
    mkrs_pkg::tail_t             in_tail;

    logic [KEYS-1:0][GW-1:0]     groups_q [MAX_ROWS];
    mkrs_pkg::tail_t             tail_q   [MAX_ROWS];
    logic [KEY_W-1:0]            key_q    [MAX_ROWS];
    logic [MAX_ROWS-1:0]         after_up;
    logic [MAX_ROWS-1:0]         swap;

    logic                                          m_tvalid_reg, m_tvalid_next;
    logic [mkrs_pkg::GROUP_NUM-1:0][GW-1:0]        m_groups_reg;
    logic [mkrs_pkg::GROUP_NUM-1:0][GW-1:0]        head_groups;
    mkrs_pkg::tail_t                               m_tail_reg;
    logic                                          m_tuser_reg;
    logic                                          m_tlast_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    mkrs_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .KEYS     (KEYS),
        .CW       (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tlast     (s_tlast),
        .out_free    (out_free),
        .s_tready    (s_tready),
        .cmd         (cmd),
        .count       (count),
        .used        (used),
        .ovf         (ovf),
        .last_emit   (last_emit)
    );

    always_comb begin
        for (int g = 0; g < KEYS; g++) begin
            in_groups[g] = s_tdata[g*GW +: GW];
        end
        in_tail.time_bits      = s_tdata[TAIL0 +: mkrs_pkg::TIME_W];
        in_tail.antenna_first  = s_tdata[TAIL0 + mkrs_pkg::TIME_W +: mkrs_pkg::ANT_W];
        in_tail.antenna_second =
            s_tdata[TAIL0 + mkrs_pkg::TIME_W + mkrs_pkg::ANT_W +: mkrs_pkg::ANT_W];
        in_tail.row_id         =
            s_tdata[TAIL0 + mkrs_pkg::TIME_W + 2*mkrs_pkg::ANT_W +: mkrs_pkg::ROW_W];
    end

    assign swap[MAX_ROWS-1] = 1'b0;

    for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
        localparam bit PAR = (i % 2) == 1;
        localparam int UP  = (i < MAX_ROWS - 1) ? i + 1 : i;
        localparam int DN  = (i > 0) ? i - 1 : i;

        mkrs_pkg::sel_t sel;
        logic           take_dn;

        if (i < MAX_ROWS - 1) begin : g_swap
            assign swap[i] = cmd.sort && (cmd.phase == PAR) &&
                             (CW'(i + 1) < count) && after_up[i];
        end

        if (i > 0) begin : g_dn
            assign take_dn = swap[i-1];
        end else begin : g_nodn
            assign take_dn = 1'b0;
        end

        always_comb begin
            if (cmd.load && count[IW-1:0] == IW'(i)) begin
                sel = mkrs_pkg::SEL_LOAD;
            end else if (swap[i] || (cmd.shift && i < MAX_ROWS - 1)) begin
                sel = mkrs_pkg::SEL_UP;
            end else if (take_dn) begin
                sel = mkrs_pkg::SEL_DN;
            end else begin
                sel = mkrs_pkg::SEL_HOLD;
            end
        end

        mkrs_cell #(
            .KEYS (KEYS)
        ) u_cell (
            .aclk      (aclk),
            .sel       (sel),
            .used      (used),
            .in_groups (in_groups),
            .in_tail   (in_tail),
            .up_groups (groups_q[UP]),
            .up_tail   (tail_q[UP]),
            .dn_groups (groups_q[DN]),
            .dn_tail   (tail_q[DN]),
            .up_key    (key_q[UP]),
            .groups_q  (groups_q[i]),
            .tail_q    (tail_q[i]),
            .key       (key_q[i]),
            .after_up  (after_up[i])
        );
    end

    for (genvar g = 0; g < mkrs_pkg::GROUP_NUM; g++) begin : g_head
        if (g < KEYS) begin : g_used
            assign head_groups[g] = (mkrs_pkg::USED_W'(g) < used) ? groups_q[0][g] : '0;
        end else begin : g_zero
            assign head_groups[g] = '0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.shift) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            m_groups_reg <= head_groups;
            m_tail_reg   <= tail_q[0];
            m_tuser_reg  <= ovf;
            m_tlast_reg  <= last_emit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_tail_reg.row_id, m_tail_reg.antenna_second,
                       m_tail_reg.antenna_first, m_tail_reg.time_bits, m_groups_reg};
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* sv/mkrs_checker.sv */
// ----------------------------------------------------------------------------
// mkrs_checker
// Port-level checks of the record sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mkrs_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [mkrs_pkg::DATA_W-1:0] m_tdata,
    input logic                        m_tlast
);

    `CHK_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "open after last")
    `CHK_IMPLY(a_open_at_last_out, m_tvalid && m_tlast, s_tready, "closed at final result")
    `CHK_NEXT(a_m_valid_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `CHK_NEXT(a_m_data_hold, m_tvalid && !m_tready, $stable(m_tdata), "m_tdata moved in stall")

endmodule

bind multi_key_record_sorter mkrs_checker u_mkrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* verif/record_order_checker.sv */
// ----------------------------------------------------------------------------
// record_order_checker
// Watches the configuration port and both stream channels of the multi-key
// record sorter. Keeps its own copy of the held records and the key count,
// sorts each set when its final record arrives, and compares every drained
// record field by field with the oldest sorted record still due.
// ----------------------------------------------------------------------------
module record_order_checker #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_KEYS = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mkrs_pkg::USED_W-1:0] cfg_wr_data,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [mkrs_pkg::DATA_W-1:0] s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [mkrs_pkg::DATA_W-1:0] m_tdata,
    input  logic                        m_tuser,
    input  logic                        m_tlast,
    output int                          pending,
    output int                          mismatches
);

    localparam logic [63:0] TIME_SIGN = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [mkrs_pkg::ROW_W-1:0]                          row_id;
        logic [mkrs_pkg::ANT_W-1:0]                          antenna_second;
        logic [mkrs_pkg::ANT_W-1:0]                          antenna_first;
        logic [mkrs_pkg::TIME_W-1:0]                         time_bits;
        logic [mkrs_pkg::GROUP_NUM-1:0][mkrs_pkg::GROUP_W-1:0] group_key;
    } record_t;

    typedef struct {
        record_t rec;
        bit      overflow;
        bit      last;
    } sorted_out_t;

    record_t                     held_rec [MAX_ROWS];
    int                          held_count;
    bit                          dropped;
    logic [mkrs_pkg::USED_W-1:0] key_sel;
    sorted_out_t                 sorted_due [$];
    int                          fail_count;
    int                          result_no;

    initial begin
        pending    = 0;
        mismatches = 0;
        fail_count = 0;
        result_no  = 0;
        held_count = 0;
        dropped    = 0;
        key_sel    = '0;
    end

    function automatic logic [63:0] time_rank(logic [63:0] t);
        logic [63:0] v;
        v = (t == TIME_SIGN) ? 64'd0 : t;
        return v[63] ? ~v : (v | TIME_SIGN);
    endfunction

    function automatic bit ranks_after(record_t a, record_t b, int used);
        logic [63:0] ra;
        logic [63:0] rb;
        for (int g = 0; g < used; g++) begin
            if (a.group_key[g] != b.group_key[g])
                return $signed(a.group_key[g]) > $signed(b.group_key[g]);
        end
        ra = time_rank(a.time_bits);
        rb = time_rank(b.time_bits);
        if (ra != rb)
            return ra > rb;
        if (a.antenna_first != b.antenna_first)
            return a.antenna_first > b.antenna_first;
        return a.antenna_second > b.antenna_second;
    endfunction

    function automatic void sort_held_records();
        int          order [MAX_ROWS];
        int          used;
        int          j;
        record_t     r;
        sorted_out_t item;
        used = (key_sel > MAX_KEYS) ? MAX_KEYS : int'(key_sel);
        for (int i = 0; i < held_count; i++) begin
            j = i;
            while (j > 0 && ranks_after(held_rec[order[j-1]], held_rec[i], used)) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < held_count; i++) begin
            r = held_rec[order[i]];
            for (int g = 0; g < mkrs_pkg::GROUP_NUM; g++) begin
                if (g >= used)
                    r.group_key[g] = '0;
            end
            item.rec      = r;
            item.overflow = dropped;
            item.last     = (i == held_count - 1);
            sorted_due.insert(sorted_due.size(), item);
        end
        held_count = 0;
        dropped    = 0;
    endfunction

    function automatic void show_record(string tag, record_t r, bit ovf, bit last);
        $display("  %s keys %0d %0d %0d %0d time %h ant %0d %0d row %h ovf %b last %b",
                 tag, $signed(r.group_key[0]), $signed(r.group_key[1]),
                 $signed(r.group_key[2]), $signed(r.group_key[3]), r.time_bits,
                 r.antenna_first, r.antenna_second, r.row_id, ovf, last);
    endfunction

    always @(posedge aclk) begin : watch
        record_t     got;
        sorted_out_t want;
        bit          bad;
        if (!aresetn) begin
            held_count = 0;
            dropped    = 0;
            key_sel    = '0;
            sorted_due.delete();
        end else begin
            if (cfg_wr_en)
                key_sel = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (held_count < MAX_ROWS) begin
                    held_rec[held_count] = record_t'(s_tdata);
                    held_count++;
                end else begin
                    dropped = 1;
                end
                if (s_tlast)
                    sort_held_records();
            end
            if (m_tvalid && m_tready) begin
                got = record_t'(m_tdata);
                if (sorted_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("checker: unexpected record %0d", result_no);
                        show_record("got", got, m_tuser, m_tlast);
                    end
                end else begin
                    want = sorted_due.pop_front();
                    bad = 0;
                    for (int g = 0; g < mkrs_pkg::GROUP_NUM; g++) begin
                        if (got.group_key[g] !== want.rec.group_key[g])
                            bad = 1;
                    end
                    if (got.time_bits !== want.rec.time_bits)
                        bad = 1;
                    if (got.antenna_first !== want.rec.antenna_first)
                        bad = 1;
                    if (got.antenna_second !== want.rec.antenna_second)
                        bad = 1;
                    if (got.row_id !== want.rec.row_id)
                        bad = 1;
                    if (m_tuser !== want.overflow || m_tlast !== want.last)
                        bad = 1;
                    if (bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("checker: mismatch on record %0d", result_no);
                            show_record("exp", want.rec, want.overflow, want.last);
                            show_record("got", got, m_tuser, m_tlast);
                        end
                    end
                end
                result_no++;
            end
        end
        pending    <= sorted_due.size();
        mismatches <= fail_count;
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the multi-key record sorter. Sends sets of records, each
// closed by a final request, under several key counts and four flow patterns
// (free flow, sender gaps, receiver stalls, both), with a directed opening
// on key, time and antenna extremes and ties; a random set overruns the
// store. A separate checker predicts and compares the sorted output.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS           = 64;
    localparam int DIRECTED_ITEMS = 22;
    localparam int RANDOM_ITEMS   = 98;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
    localparam logic [31:0] KEY_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] KEY_NEG_ONE = 32'hFFFF_FFFF;

    localparam logic [63:0] T_POS_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] T_NEG_ZERO  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] T_ONE       = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] T_MINUS_ONE = 64'hBFF0_0000_0000_0000;
    localparam logic [63:0] T_TWO       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] T_POS_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] T_NEG_INF   = 64'hFFF0_0000_0000_0000;
    localparam logic [63:0] T_POS_NAN   = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] T_NEG_NAN   = 64'hFFF8_0000_0000_0000;

    typedef enum int {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH
    } flow_mode_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [mkrs_pkg::USED_W-1:0] cfg_wr_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [mkrs_pkg::DATA_W-1:0] s_tdata;
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [mkrs_pkg::DATA_W-1:0] m_tdata;
    logic                        m_tuser;
    logic                        m_tlast;
    int                          pending;
    int                          mismatches;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int items_sent      = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    multi_key_record_sorter #(
        .MAX_ROWS       (ROWS),
        .MAX_GROUP_KEYS (4)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    record_order_checker #(
        .MAX_ROWS (ROWS),
        .MAX_KEYS (4)
    ) order_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .pending     (pending),
        .mismatches  (mismatches)
    );

    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [mkrs_pkg::DATA_W-1:0] pack_record(
        logic [31:0] k0, logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
        logic [63:0] t, logic [15:0] a1, logic [15:0] a2, logic [47:0] row);
        return {row, a2, a1, t, k3, k2, k1, k0};
    endfunction

    function automatic logic [31:0] random_key();
        case ($urandom_range(7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return KEY_NEG_ONE;
            3: return 32'd0;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] random_time();
        case ($urandom_range(11))
            0: return T_POS_ZERO;
            1: return T_NEG_ZERO;
            2: return T_ONE;
            3: return T_MINUS_ONE;
            4: return T_POS_INF;
            5: return T_NEG_INF;
            6: return T_TWO;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [mkrs_pkg::DATA_W-1:0] random_record();
        logic [15:0] a1;
        logic [15:0] a2;
        a1 = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
        a2 = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
        return pack_record(random_key(), random_key(), random_key(), random_key(),
                           random_time(), a1, a2, 48'({$urandom, $urandom}));
    endfunction

    task automatic set_flow(flow_mode_t mode);
        case (mode)
            FLOW_FREE: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            FLOW_SEND_GAPS: begin
                sender_idle_pct = 54;
                recv_stall_pct  = 0;
            end
            FLOW_RECV_STALLS: begin
                sender_idle_pct = 0;
                recv_stall_pct  = 54;
            end
            default: begin
                sender_idle_pct = 26;
                recv_stall_pct  = 26;
            end
        endcase
    endtask

    task automatic send_record(logic [mkrs_pkg::DATA_W-1:0] rec, bit last);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (last)
            s_tvalid <= 1'b0;
        items_sent++;
    endtask

    task automatic finish_set();
        do
            @(posedge aclk);
        while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_key_count(logic [mkrs_pkg::USED_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int set_no;
        int set_size;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all four keys: key extremes, signed zero, infinities and NaNs
        set_flow(FLOW_FREE);
        write_key_count(3'd4);
        send_record(pack_record(KEY_MIN, KEY_MAX, 32'd0, KEY_NEG_ONE, T_POS_ZERO,
                                16'd0, 16'd0, 48'd0), 1'b0);
        send_record(pack_record(KEY_MAX, KEY_MIN, KEY_NEG_ONE, 32'd0, T_NEG_ZERO,
                                16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF), 1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_ONE, 16'd1, 16'd1, 48'd3), 1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_MINUS_ONE, 16'd1, 16'd1, 48'd4),
                    1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_NEG_ZERO, 16'd9, 16'd0, 48'd5),
                    1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_POS_ZERO, 16'd5, 16'd0, 48'd6),
                    1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_POS_INF, 16'd0, 16'd0, 48'd7), 1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_NEG_INF, 16'd0, 16'd0, 48'd8), 1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_POS_NAN, 16'd0, 16'd0, 48'd9), 1'b0);
        send_record(pack_record(KEY_NEG_ONE, 0, 0, 0, T_NEG_NAN, 16'd0, 16'd0, 48'd10),
                    1'b1);
        finish_set();

        // no keys in use: keys drop out of the order and come out zeroed
        set_flow(FLOW_BOTH);
        write_key_count(3'd0);
        send_record(pack_record(5, 6, 7, 8, T_ONE, 16'd1, 16'd1, 48'd20), 1'b0);
        send_record(pack_record(-5, -6, -7, -8, T_ONE, 16'd1, 16'd1, 48'd21), 1'b0);
        send_record(pack_record(KEY_MAX, 0, 0, 0, T_POS_ZERO, 16'd2, 16'd0, 48'd22), 1'b0);
        send_record(pack_record(KEY_MIN, 0, 0, 0, T_NEG_ZERO, 16'd1, 16'd0, 48'd23), 1'b0);
        send_record(pack_record(1, 2, 3, 4, T_ONE, 16'd1, 16'd1, 48'd24), 1'b0);
        send_record(pack_record(9, 9, 9, 9, T_MINUS_ONE, 16'd3, 16'd3, 48'd25), 1'b1);
        finish_set();

        // key count above the limit, single record
        set_flow(FLOW_RECV_STALLS);
        write_key_count(3'd7);
        send_record(pack_record(KEY_MIN, KEY_MAX, KEY_MIN, KEY_MAX, T_TWO, 16'hFFFF, 16'd0,
                                48'h8000_0000_0001), 1'b1);
        finish_set();

        // one key: second key ignored, second antenna breaks ties
        set_flow(FLOW_SEND_GAPS);
        write_key_count(3'd1);
        send_record(pack_record(3, 100, 0, 0, T_TWO, 16'd7, 16'd9, 48'd30), 1'b0);
        send_record(pack_record(3, -100, 0, 0, T_TWO, 16'd7, 16'd0, 48'd31), 1'b0);
        send_record(pack_record(3, 0, 0, 0, T_TWO, 16'd7, 16'hFFFF, 48'd32), 1'b0);
        send_record(pack_record(3, 55, 0, 0, T_TWO, 16'd7, 16'd9, 48'd33), 1'b0);
        send_record(pack_record(3, 1, 0, 0, T_TWO, 16'd7, 16'd1, 48'd34), 1'b1);
        finish_set();

        // random sets; one of them overruns the store
        set_no = 0;
        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            set_flow(flow_mode_t'(set_no % 4));
            write_key_count(3'($urandom_range(7)));
            set_size = (set_no == 6) ? ROWS + 2 : $urandom_range(1, 12);
            for (int i = 0; i < set_size; i++)
                send_record(random_record(), i == set_size - 1);
            finish_set();
            set_no++;
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/mkrs_pkg.sv
sv/mkrs_cell.sv
sv/mkrs_ctrl.sv
sv/multi_key_record_sorter.sv
sv/mkrs_checker.sv
verif/record_order_checker.sv
verif/tb.sv
